// ===== src/baro_pressure_temperature_compensation_macros.svh =====
// assertion macros shared by the compensation block
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BPTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bptc: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define BPTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bptc: next-cycle check failed");

`endif

// ===== src/bptc_pkg.sv =====
// widths, register indexes and constants for the pressure compensation block
`timescale 1ns / 1ps

package bptc_pkg;

    // field widths
    localparam int RawW    = 24;
    localparam int CoefW   = 16;
    localparam int TempW   = 19;
    localparam int PresW   = 28;
    localparam int CfgIdxW = 3;

    // internal datapath widths
    localparam int DtW    = 25;   // raw temperature minus reference
    localparam int PrW    = 42;   // dt times a coefficient
    localparam int SqW    = 48;   // dt squared, non-negative
    localparam int AW     = 36;   // squared temperature offsets
    localparam int CorrW  = 40;   // second-order corrections
    localparam int SensW  = 40;   // sensitivity
    localparam int OffW   = 40;   // offset
    localparam int MulW   = 64;   // raw pressure times sensitivity
    localparam int XW     = 43;   // product over 2^21
    localparam int YW     = 44;   // minus offset
    localparam int PW     = 29;   // over 2^15, before saturation
    localparam int SplitW = 20;   // low slice of the sensitivity in the split multiply

    // pipeline depth from the request edge to the result sample edge
    localparam int Latency = 12;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_C1 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_C2 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_C3 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_C4 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_C5 = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_C6 = 3'd5;

    // temperature reference points in hundredths of a degree
    localparam logic signed [TempW-1:0] TempRef  = 19'sd2000;
    localparam logic signed [TempW-1:0] ColdDist = 19'sd3500;   // 20.00 C down to -15.00 C

endpackage

// ===== src/bptc_wide_mul.sv =====
// two-stage split multiplier: unsigned raw pressure times signed sensitivity
`timescale 1ns / 1ps

module bptc_wide_mul
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic        [RawW-1:0]   i_a,
    input  logic signed [SensW-1:0]  i_b,
    output logic                     o_valid,
    output logic signed [MulW-1:0]   o_prod
);

    logic                                       r_pp_vld;
    logic        [RawW+SplitW-1:0]              r_pp_lo;
    logic signed [RawW+1+SensW-SplitW-1:0]      r_pp_hi;
    logic                                       r_vld;
    logic signed [MulW-1:0]                     r_prod;

    logic        [RawW+SplitW-1:0]              n_pp_lo;
    logic signed [RawW+1+SensW-SplitW-1:0]      n_pp_hi;
    logic signed [MulW-1:0]                     n_prod;

    // partial products over the low and high slices of the sensitivity
    assign n_pp_lo = (RawW+SplitW)'(i_a) * (RawW+SplitW)'(i_b[SplitW-1:0]);
    assign n_pp_hi = $signed({1'b0, i_a}) * $signed(i_b[SensW-1:SplitW]);

    // recombine the slices
    assign n_prod = (MulW'(r_pp_hi) <<< SplitW) + $signed(MulW'(r_pp_lo));

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_pp_vld <= i_valid;
            r_vld    <= r_pp_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_prod  <= n_prod;
    end

    assign o_valid = r_vld;
    assign o_prod  = r_prod;

endmodule

// ===== src/baro_pressure_temperature_compensation.sv =====
// top level: pipelined barometric temperature and pressure compensation
`timescale 1ns / 1ps
//
// Turns one raw 24-bit pressure and temperature conversion pair into a
// compensated temperature (hundredths of a degree C) and pressure (pascals),
// with the second-order correction below 20.00 C and the extra term below
// -15.00 C. Pressure saturates to the 28-bit signed range.
//
// Request channel: a pair is taken at a rising edge with start high and
// busy low. busy is high only during reset and the cycle after it, so a
// new pair may be presented every cycle.
// Configuration channel: i_cfg_valid with o_cfg_ready (always high) writes
// i_cfg_data into calibration word i_cfg_index; other indexes are dropped.
// Write calibration words only while no request is in flight.
// Result channel: o_valid is high for one cycle with both results.
// Throughput is one pair per cycle through a 12-stage pipeline; the
// longest stages are the 64-bit recombine of the split multiplier and the
// rounding adds after it. There is no back-pressure on the results.
// Reset clears all valid bits and the calibration words to zero.

`include "baro_pressure_temperature_compensation_macros.svh"

module baro_pressure_temperature_compensation
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic        [RawW-1:0]   i_raw_pressure,
    input  logic        [RawW-1:0]   i_raw_temperature,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic        [CfgIdxW-1:0] i_cfg_index,
    input  logic        [CoefW-1:0]  i_cfg_data,
    output logic                     o_valid,
    output logic signed [TempW-1:0]  o_temperature_centi,
    output logic signed [PresW-1:0]  o_pressure_pa
);

    // calibration words
    logic [CoefW-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic             r_busy;
    logic             w_accept;

    // valid bits
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld;
    logic w_s9_vld;
    logic r_s10_vld, r_s11_vld, r_out_vld;

    // stage 1
    logic signed [DtW-1:0]   r1_dt;
    logic        [RawW-1:0]  r1_d1;
    logic signed [DtW-1:0]   n1_dt;
    // stage 2
    logic signed [PrW-1:0]   r2_p6, r2_p4, r2_p3;
    logic        [SqW-1:0]   r2_pdd;
    logic        [RawW-1:0]  r2_d1;
    logic signed [2*DtW-1:0] n2_pdd;
    // stage 3
    logic signed [PrW-1:0]   n3_p6b, n3_p4b, n3_p3b;
    logic signed [TempW-1:0] n3_q;
    logic signed [TempW-1:0] n3_e;
    logic signed [OffW-1:0]  n3_off;
    logic signed [SensW-1:0] n3_sens;
    logic signed [TempW-1:0] r3_q, r3_e, r3_temp;
    logic        [SqW-32:0]  r3_t2;
    logic signed [OffW-1:0]  r3_off;
    logic signed [SensW-1:0] r3_sens;
    logic                    r3_lo, r3_vlo;
    logic        [RawW-1:0]  r3_d1;
    // stage 4
    logic signed [2*TempW-1:0] n4_qq, n4_ee;
    logic        [AW-1:0]    r4_a, r4_b;
    logic signed [OffW-1:0]  r4_off;
    logic signed [SensW-1:0] r4_sens;
    logic                    r4_lo, r4_vlo;
    logic        [RawW-1:0]  r4_d1;
    logic signed [TempW-1:0] n4_temp;
    // stage 5
    logic        [CorrW-1:0] r5_a5, r5_b7, r5_b11;
    logic signed [OffW-1:0]  r5_off;
    logic signed [SensW-1:0] r5_sens;
    logic                    r5_lo, r5_vlo;
    logic        [RawW-1:0]  r5_d1;
    // stage 6
    logic        [CorrW-1:0] n6_off2, n6_sens2;
    logic        [CorrW-1:0] r6_off2, r6_sens2;
    logic signed [OffW-1:0]  r6_off;
    logic signed [SensW-1:0] r6_sens;
    logic        [RawW-1:0]  r6_d1;
    // stage 7
    logic signed [OffW-1:0]  r7_off;
    logic signed [SensW-1:0] r7_sens;
    logic        [RawW-1:0]  r7_d1;
    // stages 8 and 9 in the split multiplier
    logic signed [OffW-1:0]  r8_off, r9_off;
    logic signed [MulW-1:0]  w9_prod;
    // stage 10
    logic signed [MulW-1:0]  n10_pb;
    logic signed [XW-1:0]    r10_x;
    logic signed [OffW-1:0]  r10_off;
    // stage 11
    logic signed [YW-1:0]    r11_y;
    // output stage
    logic signed [YW-1:0]    n12_yb;
    logic signed [PW-1:0]    n12_p;
    logic signed [PresW-1:0] n12_sat;
    logic signed [TempW-1:0] r_temp_out;
    logic signed [PresW-1:0] r_pres_out;
    // temperature delay line, stage 4 through stage 11
    logic signed [TempW-1:0] r_temp_dly [0:7];

    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // calibration writes and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            r_c4   <= '0;
            r_c5   <= '0;
            r_c6   <= '0;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_C1:  r_c1 <= i_cfg_data;
                    REG_C2:  r_c2 <= i_cfg_data;
                    REG_C3:  r_c3 <= i_cfg_data;
                    REG_C4:  r_c4 <= i_cfg_data;
                    REG_C5:  r_c5 <= i_cfg_data;
                    REG_C6:  r_c6 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= w_accept;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s10_vld <= w_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_out_vld <= r_s11_vld;
        end
    end

    // stage 1: temperature difference to the reference
    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'b0});

    // stage 2: products with dt
    assign n2_pdd = r1_dt * r1_dt;

    // stage 3: truncating divides and first-order terms
    assign n3_p6b  = r2_p6 + $signed({{(PrW-23){1'b0}}, {23{r2_p6[PrW-1]}}});
    assign n3_p4b  = r2_p4 + $signed({{(PrW-7){1'b0}}, {7{r2_p4[PrW-1]}}});
    assign n3_p3b  = r2_p3 + $signed({{(PrW-8){1'b0}}, {8{r2_p3[PrW-1]}}});
    assign n3_q    = $signed(n3_p6b[PrW-1:23]);
    assign n3_e    = n3_q + ColdDist;
    assign n3_off  = $signed({{(OffW-CoefW-16){1'b0}}, r_c2, 16'b0})
                   + OffW'($signed(n3_p4b[PrW-1:7]));
    assign n3_sens = $signed({{(SensW-CoefW-15){1'b0}}, r_c1, 15'b0})
                   + SensW'($signed(n3_p3b[PrW-1:8]));

    // stage 4: squares of the temperature offsets
    assign n4_qq   = r3_q * r3_q;
    assign n4_ee   = r3_e * r3_e;
    assign n4_temp = r3_temp - $signed({2'b0, r3_t2});

    // stage 6: second-order corrections, applied only when cold
    always_comb begin
        n6_off2  = '0;
        n6_sens2 = '0;
        if (r5_lo) begin
            n6_off2  = (r5_a5 >> 1) + (r5_vlo ? r5_b7 : '0);
            n6_sens2 = (r5_a5 >> 2) + (r5_vlo ? (r5_b11 >> 1) : '0);
        end
    end

    // stage 10: product over 2^21 toward zero
    assign n10_pb = w9_prod + $signed({{(MulW-21){1'b0}}, {21{w9_prod[MulW-1]}}});

    // output stage: over 2^15 toward zero, then saturate
    assign n12_yb = r11_y + $signed({{(YW-15){1'b0}}, {15{r11_y[YW-1]}}});
    assign n12_p  = $signed(n12_yb[YW-1:15]);
    always_comb begin
        n12_sat = n12_p[PresW-1:0];
        if (n12_p[PW-1] != n12_p[PW-2]) begin
            n12_sat = n12_p[PW-1] ? {1'b1, {(PresW-1){1'b0}}} : {1'b0, {(PresW-1){1'b1}}};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r1_dt    <= n1_dt;
        r1_d1    <= i_raw_pressure;

        r2_p6    <= r1_dt * $signed({1'b0, r_c6});
        r2_p4    <= r1_dt * $signed({1'b0, r_c4});
        r2_p3    <= r1_dt * $signed({1'b0, r_c3});
        r2_pdd   <= n2_pdd[SqW-1:0];
        r2_d1    <= r1_d1;

        r3_q     <= n3_q;
        r3_e     <= n3_e;
        r3_temp  <= n3_q + TempRef;
        // the dt squared term only counts below 20.00 C
        r3_t2    <= n3_q[TempW-1] ? r2_pdd[SqW-1:31] : '0;
        r3_off   <= n3_off;
        r3_sens  <= n3_sens;
        r3_lo    <= n3_q[TempW-1];
        r3_vlo   <= n3_e[TempW-1];
        r3_d1    <= r2_d1;

        r4_a     <= n4_qq[AW-1:0];
        r4_b     <= n4_ee[AW-1:0];
        r4_off   <= r3_off;
        r4_sens  <= r3_sens;
        r4_lo    <= r3_lo;
        r4_vlo   <= r3_vlo;
        r4_d1    <= r3_d1;

        r5_a5    <= CorrW'(r4_a) + (CorrW'(r4_a) << 2);
        r5_b7    <= (CorrW'(r4_b) << 3) - CorrW'(r4_b);
        r5_b11   <= (CorrW'(r4_b) << 3) + (CorrW'(r4_b) << 1) + CorrW'(r4_b);
        r5_off   <= r4_off;
        r5_sens  <= r4_sens;
        r5_lo    <= r4_lo;
        r5_vlo   <= r4_vlo;
        r5_d1    <= r4_d1;

        r6_off2  <= n6_off2;
        r6_sens2 <= n6_sens2;
        r6_off   <= r5_off;
        r6_sens  <= r5_sens;
        r6_d1    <= r5_d1;

        r7_off   <= r6_off - $signed(r6_off2);
        r7_sens  <= r6_sens - $signed(r6_sens2);
        r7_d1    <= r6_d1;

        r8_off   <= r7_off;
        r9_off   <= r8_off;

        r10_x    <= $signed(n10_pb[MulW-1:21]);
        r10_off  <= r9_off;

        r11_y    <= YW'(r10_x) - YW'(r10_off);

        r_temp_out <= r_temp_dly[7];
        r_pres_out <= n12_sat;
    end

    // temperature delay line
    always_ff @(posedge i_clk) begin
        r_temp_dly[0] <= n4_temp;
        for (int i = 1; i < 8; i++) begin
            r_temp_dly[i] <= r_temp_dly[i-1];
        end
    end

    // raw pressure times corrected sensitivity
    bptc_wide_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s7_vld),
        .i_a     (r7_d1),
        .i_b     (r7_sens),
        .o_valid (w_s9_vld),
        .o_prod  (w9_prod)
    );

    assign o_valid             = r_out_vld;
    assign o_temperature_centi = r_temp_out;
    assign o_pressure_pa       = r_pres_out;

    // a result only ever follows a request taken a full pipeline earlier
    `BPTC_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, o_valid, $past(w_accept, Latency))
    // the very-cold branch sits inside the cold branch
    `BPTC_ASSERT_IMP(a_cold_nesting, i_clk, i_rst_n, r_s3_vld && r3_vlo, r3_lo)
    // requests are open again in the cycle after reset is released
    `BPTC_ASSERT_NEXT(a_busy_release, i_clk, i_rst_n, i_rst_n, !busy)

endmodule
